/* src/tpw_pkg.sv */
// Package for the three-step wrapped phase block: widths, CORDIC constants,
// the arctangent table and the pipeline payload types.
// No dependencies.
`timescale 1ns / 1ps

package tpw_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int NUM_W     = 9;    // I1-I3, signed
    localparam int DEN_W     = 11;   // 2*I2-I1-I3, signed
    localparam int FRAC_BITS = 24;
    localparam int PROD_W    = 35;   // NUM_W x sqrt(3) Q24 product
    localparam int XY_W      = 38;   // CORDIC x/y with gain headroom
    localparam int Z_W       = 23;   // angle, 2^20 units per pi
    localparam int PH_W      = 16;
    localparam int RND_SH    = 5;    // Z units per output LSB = 2^5
    localparam int ITERS     = 20;

    localparam logic signed [25:0]    SQRT3_Q24  = 26'sd29058991;
    localparam logic signed [Z_W-1:0] ANG_PI     = 23'sd1048576;
    localparam logic signed [Z_W-1:0] Z_RND_HALF = 23'sd16;

    localparam logic [PH_W-1:0] PHASE_ZERO     = 16'h0000;
    localparam logic [PH_W-1:0] PHASE_PI       = 16'h8000;
    localparam logic [PH_W-1:0] PHASE_POS_HALF = 16'h4000;
    localparam logic [PH_W-1:0] PHASE_NEG_HALF = 16'hC000;

    typedef logic signed [XY_W-1:0] t_xy;
    typedef logic signed [Z_W-1:0]  t_z;

    // atan(2^-i) in angle units, rounded to nearest
    localparam t_z ATAN_TAB [0:ITERS-1] = '{
        23'sd262144, 23'sd154753, 23'sd81767, 23'sd41506, 23'sd20834,
        23'sd10427,  23'sd5215,   23'sd2608,  23'sd1304,  23'sd652,
        23'sd326,    23'sd163,    23'sd81,    23'sd41,    23'sd20,
        23'sd10,     23'sd5,      23'sd3,     23'sd1,     23'sd1
    };

    // Cases that bypass the CORDIC result
    typedef enum logic [2:0] {
        SPEC_NONE,
        SPEC_ZERO,
        SPEC_PI,
        SPEC_POS_HALF,
        SPEC_NEG_HALF
    } t_spec;

    typedef struct packed {
        t_xy   x;
        t_xy   y;
        t_z    z;
        t_spec spec;
    } t_vec;

endpackage

/* src/tpw_front.sv */
// Front end: input register, numerator/denominator, sqrt(3) scaling and
// left-half-plane pre-rotation (three register stages).
// Depends on tpw_pkg.
`timescale 1ns / 1ps

module tpw_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic [tpw_pkg::SAMPLE_W-1:0]     i_first_sample,
    input  logic [tpw_pkg::SAMPLE_W-1:0]     i_second_sample,
    input  logic [tpw_pkg::SAMPLE_W-1:0]     i_third_sample,
    output logic                             busy,
    output logic                             o_vld,
    output tpw_pkg::t_vec                    o_vec
);

    // stage 1: differences
    logic                                r_s1_vld;
    logic signed [tpw_pkg::NUM_W-1:0]    r_num, n_num;
    logic signed [tpw_pkg::DEN_W-1:0]    r_den, n_den;

    // stage 2: scaled vector and special-case code
    logic                                r_s2_vld;
    tpw_pkg::t_xy                        r_x0, n_x0;
    tpw_pkg::t_xy                        r_y0, n_y0;
    tpw_pkg::t_spec                      r_spec, n_spec;
    logic signed [tpw_pkg::PROD_W-1:0]   w_prod;

    // stage 3: pre-rotated vector
    logic                                r_s3_vld;
    tpw_pkg::t_vec                       r_s3, n_s3;

    assign busy = 1'b0;

    always_comb begin
        n_num = signed'({1'b0, i_first_sample}) - signed'({1'b0, i_third_sample});
        n_den = signed'({2'b00, i_second_sample, 1'b0})
              - signed'({3'b000, i_first_sample})
              - signed'({3'b000, i_third_sample});
    end

    assign w_prod = r_num * tpw_pkg::SQRT3_Q24;

    always_comb begin
        n_y0 = {{(tpw_pkg::XY_W-tpw_pkg::PROD_W){w_prod[tpw_pkg::PROD_W-1]}}, w_prod};
        n_x0 = {{(tpw_pkg::XY_W-tpw_pkg::DEN_W-tpw_pkg::FRAC_BITS){r_den[tpw_pkg::DEN_W-1]}},
                r_den, {tpw_pkg::FRAC_BITS{1'b0}}};
        if (r_num == '0) begin
            n_spec = r_den[tpw_pkg::DEN_W-1] ? tpw_pkg::SPEC_PI : tpw_pkg::SPEC_ZERO;
        end else if (r_den == '0) begin
            n_spec = r_num[tpw_pkg::NUM_W-1] ? tpw_pkg::SPEC_NEG_HALF
                                             : tpw_pkg::SPEC_POS_HALF;
        end else begin
            n_spec = tpw_pkg::SPEC_NONE;
        end
    end

    // left half plane: mirror through the origin, start at +/-pi
    always_comb begin
        n_s3.spec = r_spec;
        if (r_x0[tpw_pkg::XY_W-1]) begin
            n_s3.x = -r_x0;
            n_s3.y = -r_y0;
            n_s3.z = (r_y0 > 0) ? tpw_pkg::ANG_PI : -tpw_pkg::ANG_PI;
        end else begin
            n_s3.x = r_x0;
            n_s3.y = r_y0;
            n_s3.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num  <= n_num;
        r_den  <= n_den;
        r_x0   <= n_x0;
        r_y0   <= n_y0;
        r_spec <= n_spec;
        r_s3   <= n_s3;
    end

    assign o_vld = r_s3_vld;
    assign o_vec = r_s3;

    a_vld_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_s3_vld == $past(r_s2_vld)))
        else $error("front valid lost or invented");

    a_prerot_right_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_vld && (r_s3.spec == tpw_pkg::SPEC_NONE)) |-> (r_s3.x > 0))
        else $error("pre-rotation left vector outside right half plane");

endmodule

/* src/tpw_cordic.sv */
// Vectoring CORDIC, one register stage per micro-rotation.
// Depends on tpw_pkg.
`timescale 1ns / 1ps

module tpw_cordic (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  tpw_pkg::t_vec  i_vec,
    output logic           o_vld,
    output tpw_pkg::t_vec  o_vec
);

    logic          r_vld [0:tpw_pkg::ITERS-1];
    tpw_pkg::t_vec r_vec [0:tpw_pkg::ITERS-1];
    tpw_pkg::t_vec n_vec [0:tpw_pkg::ITERS-1];
    tpw_pkg::t_vec w_src [0:tpw_pkg::ITERS-1];

    always_comb begin
        w_src[0] = i_vec;
        for (int i = 1; i < tpw_pkg::ITERS; i++) begin
            w_src[i] = r_vec[i-1];
        end
    end

    // shifts are floor (arithmetic) as in the fixed-point spec
    always_comb begin
        tpw_pkg::t_xy cx;
        tpw_pkg::t_xy cy;
        for (int i = 0; i < tpw_pkg::ITERS; i++) begin
            cx = w_src[i].x;
            cy = w_src[i].y;
            n_vec[i].spec = w_src[i].spec;
            if (!cy[tpw_pkg::XY_W-1]) begin
                n_vec[i].x = cx + (cy >>> i);
                n_vec[i].y = cy - (cx >>> i);
                n_vec[i].z = w_src[i].z + tpw_pkg::ATAN_TAB[i];
            end else begin
                n_vec[i].x = cx - (cy >>> i);
                n_vec[i].y = cy + (cx >>> i);
                n_vec[i].z = w_src[i].z - tpw_pkg::ATAN_TAB[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tpw_pkg::ITERS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int i = 1; i < tpw_pkg::ITERS; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < tpw_pkg::ITERS; i++) begin
            r_vec[i] <= n_vec[i];
        end
    end

    assign o_vld = r_vld[tpw_pkg::ITERS-1];
    assign o_vec = r_vec[tpw_pkg::ITERS-1];

    // x never shrinks once the vector is in the right half plane
    a_x_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> !o_vec.x[tpw_pkg::XY_W-1])
        else $error("CORDIC x went negative");

endmodule

/* src/tpw_round.sv */
// Output stage: rounds the angle to a 16-bit binary angle, applies the
// axis special cases and registers the request result. Depends on tpw_pkg.
`timescale 1ns / 1ps

module tpw_round (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  tpw_pkg::t_vec                i_vec,
    output logic                         o_strobe,
    output logic [tpw_pkg::PH_W-1:0]     o_wrapped_phase
);

    logic                        r_strobe;
    logic [tpw_pkg::PH_W-1:0]    r_phase, n_phase;
    tpw_pkg::t_z                 w_zr;

    // round half up, then keep 16 bits (wraps +pi to -pi)
    assign w_zr = i_vec.z + tpw_pkg::Z_RND_HALF;

    always_comb begin
        unique case (i_vec.spec)
            tpw_pkg::SPEC_NONE:
                n_phase = w_zr[tpw_pkg::PH_W+tpw_pkg::RND_SH-1:tpw_pkg::RND_SH];
            tpw_pkg::SPEC_ZERO:     n_phase = tpw_pkg::PHASE_ZERO;
            tpw_pkg::SPEC_PI:       n_phase = tpw_pkg::PHASE_PI;
            tpw_pkg::SPEC_POS_HALF: n_phase = tpw_pkg::PHASE_POS_HALF;
            tpw_pkg::SPEC_NEG_HALF: n_phase = tpw_pkg::PHASE_NEG_HALF;
            default:                n_phase = tpw_pkg::PHASE_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
    end

    assign o_strobe        = r_strobe;
    assign o_wrapped_phase = r_phase;

    a_pi_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vld && (i_vec.spec == tpw_pkg::SPEC_PI)) |=> (o_wrapped_phase == tpw_pkg::PHASE_PI))
        else $error("+pi not emitted as -32768");

endmodule

/* src/three_step_wrapped_phase.sv */
// Three-step phase-shift wrapped phase: atan2(sqrt(3)*(I1-I3), 2*I2-I1-I3).
// The result strobe comes out of 3 front stages, 20 CORDIC micro-rotation
// stages and 1 output register.
// Throughput: one pixel per clock; busy is always low, results cannot stall.
// Synchronous active-low reset clears the valid bits only; no clearing pass.
`timescale 1ns / 1ps

module three_step_wrapped_phase (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic [tpw_pkg::SAMPLE_W-1:0]     i_first_sample,
    input  logic [tpw_pkg::SAMPLE_W-1:0]     i_second_sample,
    input  logic [tpw_pkg::SAMPLE_W-1:0]     i_third_sample,
    output logic                             busy,
    output logic                             o_strobe,
    output logic signed [tpw_pkg::PH_W-1:0]  o_wrapped_phase
);

    logic                      w_front_vld;
    tpw_pkg::t_vec             w_front_vec;
    logic                      w_cordic_vld;
    tpw_pkg::t_vec             w_cordic_vec;
    logic [tpw_pkg::PH_W-1:0]  w_phase;

    tpw_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_first_sample  (i_first_sample),
        .i_second_sample (i_second_sample),
        .i_third_sample  (i_third_sample),
        .busy            (busy),
        .o_vld           (w_front_vld),
        .o_vec           (w_front_vec)
    );

    tpw_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_front_vld),
        .i_vec   (w_front_vec),
        .o_vld   (w_cordic_vld),
        .o_vec   (w_cordic_vec)
    );

    tpw_round u_round (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vld           (w_cordic_vld),
        .i_vec           (w_cordic_vec),
        .o_strobe        (o_strobe),
        .o_wrapped_phase (w_phase)
    );

    assign o_wrapped_phase = signed'(w_phase);

endmodule

/* bench/three_step_wrapped_phase_tb.sv */
// Testbench for three_step_wrapped_phase: drives directed corner pixels, then random pixels
// under several input idling patterns. Each phase result is checked against a CORDIC predictor.
// Depends on tpw_pkg and the three_step_wrapped_phase RTL.
`timescale 1ns / 1ps

module three_step_wrapped_phase_tb;

    localparam int SW = tpw_pkg::SAMPLE_W;
    localparam int PW = tpw_pkg::PH_W;

    localparam int PIPE_LATENCY   = 23;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;
    localparam int MAX_GAP        = 200;
    localparam int ITEMS_PER_TEST = 350;

    // CORDIC predictor constants: angle has 2^20 units per pi
    localparam int     CORDIC_STEPS = 20;
    localparam longint ROOT3_Q24    = 29058991;
    localparam longint UNIT_Q24     = 16777216;
    localparam longint HALF_TURN    = 1048576;
    localparam longint ROUND_HALF   = 16;
    localparam int     OUT_SHIFT    = 5;
    localparam longint ARCTAN_LUT [CORDIC_STEPS] = '{
        262144, 154753, 81767, 41506, 20834, 10427, 5215, 2608, 1304, 652,
        326, 163, 81, 41, 20, 10, 5, 3, 1, 1
    };

    localparam logic [PW-1:0] ANGLE_ZERO = 16'h0000;
    localparam logic [PW-1:0] ANGLE_PI   = 16'h8000;
    localparam logic [PW-1:0] ANGLE_UP   = 16'h4000;
    localparam logic [PW-1:0] ANGLE_DOWN = 16'hC000;

    typedef struct {
        logic [SW-1:0] s1;
        logic [SW-1:0] s2;
        logic [SW-1:0] s3;
        logic [PW-1:0] phase;
    } t_pixel_phase;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [SW-1:0]        i_first_sample = '0;
    logic [SW-1:0]        i_second_sample = '0;
    logic [SW-1:0]        i_third_sample = '0;
    logic                 busy;
    logic                 o_strobe;
    logic signed [PW-1:0] o_wrapped_phase;

    t_pixel_phase pending_phase_q[$];
    t_pixel_phase head_phase;
    t_pixel_phase tail_phase;
    int pixels_accepted = 0;
    int phases_checked  = 0;
    int check_failures  = 0;
    int quiet_cycles    = 0;
    int zero_num_seen   = 0;
    int zero_den_seen   = 0;

    three_step_wrapped_phase u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_first_sample  (i_first_sample),
        .i_second_sample (i_second_sample),
        .i_third_sample  (i_third_sample),
        .busy            (busy),
        .o_strobe        (o_strobe),
        .o_wrapped_phase (o_wrapped_phase)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // atan2(sqrt(3)*(I1-I3), 2*I2-I1-I3) as a 16-bit binary angle
    function automatic logic [PW-1:0] predict_phase(input logic [SW-1:0] s1, s2, s3);
        longint num, den, x, y, z, nx, ny;
        num = longint'(s1) - longint'(s3);
        den = 2 * longint'(s2) - longint'(s1) - longint'(s3);
        if (num == 0)
            return (den < 0) ? ANGLE_PI : ANGLE_ZERO;
        if (den == 0)
            return (num > 0) ? ANGLE_UP : ANGLE_DOWN;
        x = den * UNIT_Q24;
        y = num * ROOT3_Q24;
        z = 0;
        // left half plane: rotate by pi first
        if (x < 0) begin
            z = (y > 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + ARCTAN_LUT[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - ARCTAN_LUT[i];
            end
            x = nx;
            y = ny;
        end
        return PW'((z + ROUND_HALF) >>> OUT_SHIFT);
    endfunction

    // Result checker, request monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles = quiet_cycles + 1;
            if (o_strobe === 1'b1) begin
                quiet_cycles = 0;
                if (pending_phase_q.size() == 0) begin
                    check_failures = check_failures + 1;
                    if (check_failures <= MAX_REPORTS)
                        $display("unexpected result: phase %0d with no request pending",
                                 o_wrapped_phase);
                end else begin
                    head_phase = pending_phase_q.pop_front();
                    phases_checked = phases_checked + 1;
                    if (o_wrapped_phase !== head_phase.phase) begin
                        check_failures = check_failures + 1;
                        if (check_failures <= MAX_REPORTS)
                            $display("phase mismatch I1=%0d I2=%0d I3=%0d: expected %0d, got %0d",
                                     head_phase.s1, head_phase.s2, head_phase.s3,
                                     $signed(head_phase.phase), o_wrapped_phase);
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                quiet_cycles = 0;
                pixels_accepted = pixels_accepted + 1;
                if (i_first_sample == i_third_sample)
                    zero_num_seen = zero_num_seen + 1;
                if (2 * int'(i_second_sample) == int'(i_first_sample) + int'(i_third_sample))
                    zero_den_seen = zero_den_seen + 1;
                tail_phase.s1    = i_first_sample;
                tail_phase.s2    = i_second_sample;
                tail_phase.s3    = i_third_sample;
                tail_phase.phase = predict_phase(i_first_sample, i_second_sample,
                                                 i_third_sample);
                pending_phase_q.insert(pending_phase_q.size(), tail_phase);
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request or result for %0d cycles", quiet_cycles);
                $display("** three_step_wrapped_phase: FAILED **");
                $finish;
            end
        end
    end

    // Called at a rising edge; returns at the edge that accepts the request, start left high
    task automatic send_pixel(input logic [SW-1:0] s1, s2, s3);
        start           <= 1'b1;
        i_first_sample  <= s1;
        i_second_sample <= s2;
        i_third_sample  <= s3;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
    endtask

    // Idle cycles carry junk on the sample ports, which must be ignored
    task automatic idle_gap(input int idle_pct);
        int n;
        n = 0;
        while (n < MAX_GAP && $urandom_range(99) < idle_pct)
            n++;
        repeat (n) begin
            start           <= 1'b0;
            i_first_sample  <= SW'($urandom);
            i_second_sample <= SW'($urandom);
            i_third_sample  <= SW'($urandom);
            @(posedge i_clk);
        end
    endtask

    // first wait lets the monitor log the request accepted at this edge
    task automatic wait_all_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_phase_q.size() != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Random pixel, biased toward the axis cases and toward angles near +/-pi
    task automatic send_random_pixel();
        logic [SW-1:0] s1, s2, s3;
        int kind;
        s1 = SW'($urandom);
        s2 = SW'($urandom);
        s3 = SW'($urandom);
        kind = $urandom_range(15);
        case (kind)
            0: begin
                s3 = s1;
            end
            1, 2: begin
                if (s1[0] != s3[0])
                    s3[0] = ~s3[0];
                s2 = SW'((int'(s1) + int'(s3)) / 2);
            end
            3: begin
                s2 = SW'($urandom_range(3));
                s3 = (s1 == 8'd255) ? 8'd254 : s1 + 8'd1;
                if ($urandom_range(1))
                    {s1, s3} = {s3, s1};
            end
            default: begin
            end
        endcase
        send_pixel(s1, s2, s3);
    endtask

    task automatic test_directed();
        send_pixel(8'd0,   8'd0,   8'd0);     // both terms zero
        send_pixel(8'd255, 8'd255, 8'd255);   // both terms zero, all bits set
        send_pixel(8'd100, 8'd200, 8'd100);   // zero numerator, positive denominator
        send_pixel(8'd100, 8'd0,   8'd100);   // zero numerator, negative: +pi wraps
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd200, 8'd150, 8'd100);   // zero denominator, +pi/2
        send_pixel(8'd100, 8'd150, 8'd200);   // zero denominator, -pi/2
        send_pixel(8'd255, 8'd128, 8'd1);
        send_pixel(8'd255, 8'd0,   8'd0);     // left half plane, numerator positive
        send_pixel(8'd0,   8'd0,   8'd255);   // left half plane, numerator negative
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd128, 8'd0,   8'd127);   // just below +pi
        send_pixel(8'd127, 8'd0,   8'd128);   // just above -pi
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd128, 8'd255, 8'd127);   // near zero from both sides
        send_pixel(8'd127, 8'd255, 8'd128);
        send_pixel(8'd170, 8'd85,  8'd85);
        send_pixel(8'd85,  8'd170, 8'd170);
        send_pixel(8'd85,  8'd85,  8'd170);
        wait_all_results();
    endtask

    task automatic test_back_to_back();
        repeat (ITEMS_PER_TEST)
            send_random_pixel();
    endtask

    task automatic test_sparse_input();
        repeat (ITEMS_PER_TEST) begin
            idle_gap(78);
            send_random_pixel();
        end
    endtask

    task automatic test_bursty_input_with_drain();
        for (int n = 0; n < ITEMS_PER_TEST; n++) begin
            if (n == ITEMS_PER_TEST / 2)
                wait_all_results();
            idle_gap(32);
            send_random_pixel();
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_back_to_back();
        test_sparse_input();
        test_bursty_input_with_drain();

        wait_all_results();
        repeat (PIPE_LATENCY + 5) @(posedge i_clk);
        if (pending_phase_q.size() != 0) begin
            $display("%0d expected results never arrived", pending_phase_q.size());
            check_failures = check_failures + pending_phase_q.size();
        end

        $display("Checked %0d phase results from %0d pixels: corner cases, back-to-back,",
                 phases_checked, pixels_accepted);
        $display("sparse and bursty input; %0d zero-numerator and %0d zero-denominator pixels.",
                 zero_num_seen, zero_den_seen);
        if (check_failures == 0) begin
            $display("** three_step_wrapped_phase: PASSED **");
        end else begin
            $display("%0d check failures", check_failures);
            $display("** three_step_wrapped_phase: FAILED **");
        end
        $finish;
    end

endmodule
